/* rtl/core/bmalu_pkg.sv */
`default_nettype none

package bmalu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned OP_W     = 5;
  localparam int unsigned SHAMT_W  = 5;
  localparam int unsigned COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ANDN  = 5'd0,
    OP_ORN   = 5'd1,
    OP_XNOR  = 5'd2,
    OP_MAX   = 5'd3,
    OP_MAXU  = 5'd4,
    OP_MIN   = 5'd5,
    OP_MINU  = 5'd6,
    OP_ROL   = 5'd7,
    OP_ROR   = 5'd8,
    OP_SEXTB = 5'd9,
    OP_SEXTH = 5'd10,
    OP_ZEXTB = 5'd11,
    OP_ZEXTH = 5'd12,
    OP_CLZ   = 5'd13,
    OP_CTZ   = 5'd14,
    OP_CPOP  = 5'd15,
    OP_RORI  = 5'd16
  } op_e;

  // Binary search over halves; all-zero input counts as the full width.
  function automatic logic [COUNT_W-1:0] clz32(input logic [XLEN-1:0] v);
    logic [XLEN-1:0]    x;
    logic [COUNT_W-1:0] n;
    x = v;
    n = '0;
    if (v == '0) begin
      n = COUNT_W'(XLEN);
    end else begin
      if (x[31:16] == '0) begin n[4] = 1'b1; x = x << 16; end
      if (x[31:24] == '0) begin n[3] = 1'b1; x = x << 8;  end
      if (x[31:28] == '0) begin n[2] = 1'b1; x = x << 4;  end
      if (x[31:30] == '0) begin n[1] = 1'b1; x = x << 2;  end
      if (!x[31])         begin n[0] = 1'b1;              end
    end
    return n;
  endfunction

  function automatic logic [XLEN-1:0] bitrev32(input logic [XLEN-1:0] v);
    logic [XLEN-1:0] r;
    r = '0;
    for (int i = 0; i < XLEN; i++) begin
      r[i] = v[XLEN-1-i];
    end
    return r;
  endfunction

  // Count per nibble, then add the eight partial counts.
  function automatic logic [COUNT_W-1:0] cpop32(input logic [XLEN-1:0] v);
    logic [2:0]         nib [8];
    logic [COUNT_W-1:0] sum;
    for (int i = 0; i < 8; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + COUNT_W'(nib[i]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bmalu_exec.sv */
`default_nettype none

module bmalu_exec (
  input  wire logic [bmalu_pkg::OP_W-1:0]    op_i,
  input  wire logic [bmalu_pkg::XLEN-1:0]    a_i,
  input  wire logic [bmalu_pkg::XLEN-1:0]    b_i,
  input  wire logic [bmalu_pkg::SHAMT_W-1:0] imm_i,
  output logic      [bmalu_pkg::XLEN-1:0]    result_o
);

  localparam int unsigned XLEN = bmalu_pkg::XLEN;

  logic [bmalu_pkg::SHAMT_W-1:0] shamt;
  logic [2*XLEN-1:0]             dbl;
  logic [2*XLEN-1:0]             ror_full;
  logic [2*XLEN-1:0]             rol_full;
  logic                          lt_s;
  logic                          lt_u;

  // Rotate amount: immediate for rori, low bits of the second operand otherwise.
  assign shamt    = (bmalu_pkg::op_e'(op_i) == bmalu_pkg::OP_RORI) ? imm_i
                                                                  : b_i[bmalu_pkg::SHAMT_W-1:0];
  assign dbl      = {a_i, a_i};
  assign ror_full = dbl >> shamt;
  assign rol_full = dbl << shamt;

  assign lt_s = $signed(a_i) < $signed(b_i);
  assign lt_u = a_i < b_i;

  always_comb begin
    unique case (bmalu_pkg::op_e'(op_i)) inside
      bmalu_pkg::OP_ANDN:  result_o = a_i & ~b_i;
      bmalu_pkg::OP_ORN:   result_o = a_i | ~b_i;
      bmalu_pkg::OP_XNOR:  result_o = ~(a_i ^ b_i);
      bmalu_pkg::OP_MAX:   result_o = lt_s ? b_i : a_i;
      bmalu_pkg::OP_MAXU:  result_o = lt_u ? b_i : a_i;
      bmalu_pkg::OP_MIN:   result_o = lt_s ? a_i : b_i;
      bmalu_pkg::OP_MINU:  result_o = lt_u ? a_i : b_i;
      bmalu_pkg::OP_ROL:   result_o = rol_full[2*XLEN-1:XLEN];
      bmalu_pkg::OP_ROR,
      bmalu_pkg::OP_RORI:  result_o = ror_full[XLEN-1:0];
      bmalu_pkg::OP_SEXTB: result_o = {{(XLEN-8){a_i[7]}}, a_i[7:0]};
      bmalu_pkg::OP_SEXTH: result_o = {{(XLEN-16){a_i[15]}}, a_i[15:0]};
      bmalu_pkg::OP_ZEXTB: result_o = {{(XLEN-8){1'b0}}, a_i[7:0]};
      bmalu_pkg::OP_ZEXTH: result_o = {{(XLEN-16){1'b0}}, a_i[15:0]};
      bmalu_pkg::OP_CLZ:   result_o = XLEN'(bmalu_pkg::clz32(a_i));
      bmalu_pkg::OP_CTZ:   result_o = XLEN'(bmalu_pkg::clz32(bmalu_pkg::bitrev32(a_i)));
      bmalu_pkg::OP_CPOP:  result_o = XLEN'(bmalu_pkg::cpop32(a_i));
      default:             result_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/bitmanip_alu_32_core.sv */
`default_nettype none

// 32-bit bit-manipulation ALU for a subset of Zbb (andn, orn, xnor, min/max,
// rol/ror/rori, sign and zero extension, clz, ctz, cpop). One transfer is
// accepted every cycle while in_stall_o is low, and its result is registered:
// the operands land in an input register, pass through one level of
// combinational logic and are captured in the result register. Throughput is
// set by that single pass, so a steady stream runs at one item per cycle
// while out_stall_i is low; out_stall_i holds both registers and reaches
// in_stall_o only when both are full. Unassigned operation codes return zero;
// clz and ctz of zero return 32.
module bitmanip_alu_32_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [bmalu_pkg::OP_W-1:0]        operation_i,
  input  wire logic [bmalu_pkg::XLEN-1:0]        first_operand_i,
  input  wire logic [bmalu_pkg::XLEN-1:0]        second_operand_i,
  input  wire logic [bmalu_pkg::SHAMT_W-1:0]     immediate_amount_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [bmalu_pkg::XLEN-1:0]        result_value_o
);

  logic                          in_vld_q, in_vld_d;
  logic [bmalu_pkg::OP_W-1:0]    op_q;
  logic [bmalu_pkg::XLEN-1:0]    a_q, b_q;
  logic [bmalu_pkg::SHAMT_W-1:0] imm_q;
  logic                          res_vld_q, res_vld_d;
  logic [bmalu_pkg::XLEN-1:0]    res_q;
  logic [bmalu_pkg::XLEN-1:0]    res_d;
  logic                          res_load;
  logic                          in_load;

  // Advance each stage when the one after it is empty or draining.
  assign res_load   = !res_vld_q || !out_stall_i;
  assign in_load    = !in_vld_q || res_load;
  assign in_stall_o = !in_load;

  assign in_vld_d  = in_load ? in_valid_i : in_vld_q;
  assign res_vld_d = res_load ? in_vld_q : res_vld_q;

  bmalu_exec u_exec (
    .op_i     (op_q),
    .a_i      (a_q),
    .b_i      (b_q),
    .imm_i    (imm_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      op_q  <= operation_i;
      a_q   <= first_operand_i;
      b_q   <= second_operand_i;
      imm_q <= immediate_amount_i;
    end
    if (res_load && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign result_value_o = res_q;

endmodule

`default_nettype wire

/* sim/bitmanip_alu_32_core_test.sv */
`timescale 1ns / 100ps

module bitmanip_alu_32_core_test;
  import bmalu_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [XLEN-1:0]    a;
    logic [XLEN-1:0]    b;
    logic [SHAMT_W-1:0] imm;
  } alu_op_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [XLEN-1:0] value;
  } alu_result_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i        = '0;
  logic [XLEN-1:0]     first_operand_i    = '0;
  logic [XLEN-1:0]     second_operand_i   = '0;
  logic [SHAMT_W-1:0]  immediate_amount_i = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [XLEN-1:0]     result_value_o;

  alu_op_t     pending_ops[$];
  alu_result_t pending_results[$];

  int unsigned total_items     = 0;
  int unsigned items_sent      = 0;
  int unsigned unassigned_sent = 0;
  int unsigned results_taken   = 0;
  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;

  int unsigned src_gap    = 0;
  int unsigned src_burst  = 0;
  int unsigned sink_left  = 0;
  int unsigned sink_burst = 0;
  logic        next_valid;
  alu_op_t     next_op;
  alu_result_t got_back;

  bitmanip_alu_32_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .first_operand_i    (first_operand_i),
    .second_operand_i   (second_operand_i),
    .immediate_amount_i (immediate_amount_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_value_o     (result_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [XLEN-1:0] rotate_right(input logic [XLEN-1:0] v,
                                                   input logic [SHAMT_W-1:0] s);
    if (s == '0) return v;
    return (v >> s) | (v << (XLEN - s));
  endfunction

  function automatic logic [XLEN-1:0] zbb_result(input logic [OP_W-1:0]    op,
                                                 input logic [XLEN-1:0]    a,
                                                 input logic [XLEN-1:0]    b,
                                                 input logic [SHAMT_W-1:0] imm);
    logic [XLEN-1:0] r;
    int unsigned     n;
    int              i;
    n = 0;
    case (op)
      OP_ANDN:  r = a & ~b;
      OP_ORN:   r = a | ~b;
      OP_XNOR:  r = ~(a ^ b);
      OP_MAX:   r = ($signed(b) < $signed(a)) ? a : b;
      OP_MAXU:  r = (a > b) ? a : b;
      OP_MIN:   r = ($signed(a) < $signed(b)) ? a : b;
      OP_MINU:  r = (a < b) ? a : b;
      // rotate left by s is rotate right by the complement, mod 32
      OP_ROL:   r = rotate_right(a, SHAMT_W'(6'd32 - {1'b0, b[4:0]}));
      OP_ROR:   r = rotate_right(a, b[4:0]);
      OP_SEXTB: r = {{24{a[7]}}, a[7:0]};
      OP_SEXTH: r = {{16{a[15]}}, a[15:0]};
      OP_ZEXTB: r = {24'h0, a[7:0]};
      OP_ZEXTH: r = {16'h0, a[15:0]};
      OP_CLZ: begin
        for (i = XLEN - 1; i >= 0 && !a[i]; i--) n++;
        r = XLEN'(n);
      end
      OP_CTZ: begin
        for (i = 0; i < XLEN && !a[i]; i++) n++;
        r = XLEN'(n);
      end
      OP_CPOP: begin
        for (i = 0; i < XLEN; i++) n += a[i];
        r = XLEN'(n);
      end
      OP_RORI:  r = rotate_right(a, imm);
      default:  r = '0;
    endcase
    return r;
  endfunction

  // Mostly back to back, some short pauses, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] one_hot;
    one_hot = XLEN'(1) << $urandom_range(0, XLEN - 1);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return one_hot;
      5:       return ~one_hot;
      6:       return XLEN'($urandom_range(0, 255));
      7:       return $urandom() >> $urandom_range(0, 31);
      8:       return $urandom() << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(input logic [OP_W-1:0] op, input logic [XLEN-1:0] a,
                        input logic [XLEN-1:0] b, input logic [SHAMT_W-1:0] imm);
    pending_ops.push_back('{op: op, a: a, b: b, imm: imm});
  endtask

  // Driver: hold the payload while stalled, load the next item after a gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back('{op: operation_i,
            value: zbb_result(operation_i, first_operand_i, second_operand_i,
                              immediate_amount_i)});
        items_sent++;
        if (operation_i > OP_RORI) unassigned_sent++;
        next_valid = 1'b0;
        if (src_burst > 0) begin
          src_burst--;
          src_gap = 0;
        end else if ($urandom_range(0, 59) == 0) begin
          src_burst = $urandom_range(30, 80);
          src_gap = 0;
        end else begin
          src_gap = pick_gap();
        end
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          next_valid = 1'b1;
          operation_i        <= next_op.op;
          first_operand_i    <= next_op.a;
          second_operand_i   <= next_op.b;
          immediate_amount_i <= next_op.imm;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (sink_left > 0) begin
      sink_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (sink_burst > 0) sink_burst--;
      else if ($urandom_range(0, 199) == 0) sink_burst = $urandom_range(50, 150);
      else sink_left = pick_gap();
    end
  end

  // Monitor: compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result_value: expected nothing, actual %h", result_value_o);
        mismatches++;
      end else begin
        got_back = pending_results.pop_front();
        results_taken++;
        if (result_value_o !== got_back.value) begin
          $error("result_value (operation %0d): expected %h, actual %h",
                 got_back.op, got_back.value, result_value_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;

    // Directed: field extremes, every operation, zero counts, zero rotates.
    add_op(OP_ANDN,  32'hFFFF_FFFF, 32'h0000_0000, 5'd0);
    add_op(OP_ANDN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    add_op(OP_ORN,   32'h0000_0000, 32'h0000_0000, 5'd0);
    add_op(OP_XNOR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd0);
    add_op(OP_MAX,   32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    add_op(OP_MAXU,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    add_op(OP_MIN,   32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    add_op(OP_MINU,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
    add_op(OP_MAX,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    add_op(OP_ROL,   32'h8000_0001, 32'hFFFF_FFE0, 5'd0);
    add_op(OP_ROL,   32'h8000_0001, 32'h0000_0001, 5'd0);
    add_op(OP_ROR,   32'h8000_0001, 32'h0000_001F, 5'd0);
    add_op(OP_ROR,   32'h1234_5678, 32'h0000_0000, 5'd31);
    add_op(OP_SEXTB, 32'h0000_0080, 32'h0, 5'd0);
    add_op(OP_SEXTB, 32'hFFFF_FF7F, 32'h0, 5'd0);
    add_op(OP_SEXTH, 32'h0000_8000, 32'h0, 5'd0);
    add_op(OP_SEXTH, 32'hFFFF_7FFF, 32'h0, 5'd0);
    add_op(OP_ZEXTB, 32'hFFFF_FFFF, 32'h0, 5'd0);
    add_op(OP_ZEXTH, 32'hFFFF_FFFF, 32'h0, 5'd0);
    add_op(OP_CLZ,   32'h0000_0000, 32'h0, 5'd0);
    add_op(OP_CLZ,   32'h0000_0001, 32'h0, 5'd0);
    add_op(OP_CTZ,   32'h0000_0000, 32'h0, 5'd0);
    add_op(OP_CTZ,   32'h8000_0000, 32'h0, 5'd0);
    add_op(OP_CPOP,  32'hFFFF_FFFF, 32'h0, 5'd0);
    add_op(OP_RORI,  32'hDEAD_BEEF, 32'h0000_0011, 5'd0);
    add_op(OP_RORI,  32'hDEAD_BEEF, 32'h0000_0000, 5'd31);
    add_op(5'd17,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
    add_op(5'd31,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      if ($urandom_range(0, 19) == 0) op = OP_W'($urandom_range(17, 31));
      else op = OP_W'($urandom_range(0, 16));
      a = pick_operand();
      // equal operands now and then, for the min/max tie
      b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      add_op(op, a, b, SHAMT_W'($urandom_range(0, 31)));
    end
    total_items = pending_ops.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_taken < total_items) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $error("result_value: %0d predictions never matched by a result",
             pending_results.size());
      mismatches++;
    end

    $display("Sent %0d items (%0d with unassigned codes) across all Zbb operations,",
             items_sent, unassigned_sent);
    $display("checked %0d results under random gaps and stalls, %0d mismatches.",
             results_taken, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
